// File: sv/rhh_pkg.sv
// ----------------------------------------------------------------------------
// rhh_pkg
// Shared types and codes for the Robin Hood hash table block.
// ----------------------------------------------------------------------------
package rhh_pkg;

  // Request action codes.
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // Width of the precomputed hash.
  localparam int HASH_W = 32;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] lookup_key;
    logic [31:0] key_hash;
    logic [31:0] entry_value;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic [1:0]  status;
    logic [4:0]  stored_count;
  } rsp_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_MOD,
    FR_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_START,
    BK_FIND,
    BK_PSTART,
    BK_PLACE,
    BK_SHIFT,
    BK_DONE
  } back_state_e;

endpackage

// File: sv/rhh_ram.sv
// ----------------------------------------------------------------------------
// rhh_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module rhh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/rhh_fifo.sv
// ----------------------------------------------------------------------------
// rhh_fifo
// Two-entry queue between the front and the back of the table.
// ----------------------------------------------------------------------------
module rhh_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] data_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = data_q[rd_ptr_q];

  // Storage; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      data_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i && !full_o) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i && valid_o) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push_i && !full_o) - 2'(pop_i && valid_o);
    end
  end

endmodule

// File: sv/rhh_front.sv
// ----------------------------------------------------------------------------
// rhh_front
// Accepts requests and reduces the hash to a home slot by reciprocal multiply.
// ----------------------------------------------------------------------------
module rhh_front #(
  parameter int CAPACITY = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rhh_pkg::req_t     in_data_i,
  output logic              push_o,
  output rhh_pkg::req_t     push_req_o,
  output logic [$clog2(CAPACITY)-1:0] push_home_o,
  input  logic              full_i
);
  import rhh_pkg::*;

  localparam int IW     = $clog2(CAPACITY);
  localparam int QSHIFT = HASH_W + IW;
  localparam int PW     = 2 * HASH_W + 1;
  // Reciprocal rounded up; the quotient is exact for every hash value.
  localparam logic [HASH_W:0] RECIP = (HASH_W + 1)'(
    ((64'd1 << QSHIFT) + 64'(CAPACITY) - 64'd1) / 64'(CAPACITY));
  localparam logic [HASH_W-1:0] CAP_W = HASH_W'(CAPACITY);

  front_state_e       state_q, state_d;
  req_t               req_q;
  logic [PW-1:0]      prod;
  logic [HASH_W-1:0]  quot_q, quot_d, rem;
  logic               accept;

  assign accept = (state_q == FR_IDLE) && en_i && in_valid_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      FR_IDLE: if (accept) state_d = FR_MOD;
      FR_MOD:  state_d = FR_PUSH;
      FR_PUSH: if (!full_i) state_d = FR_IDLE;
      default: state_d = FR_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_stall_o = !((state_q == FR_IDLE) && en_i);
    push_o     = (state_q == FR_PUSH);
  end

  // Quotient is registered in FR_MOD; the remainder is formed from it in FR_PUSH.
  assign prod   = PW'(req_q.key_hash) * PW'(RECIP);
  assign quot_d = HASH_W'(prod >> QSHIFT);
  assign rem    = req_q.key_hash - quot_q * CAP_W;

  assign push_req_o  = req_q;
  assign push_home_o = rem[IW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_data_i;
    end
    if (state_q == FR_MOD) begin
      quot_q <= quot_d;
    end
  end

endmodule

// File: sv/rhh_back.sv
// ----------------------------------------------------------------------------
// rhh_back
// Probe sequencer: find, Robin Hood placement and backward-shift delete.
// ----------------------------------------------------------------------------
module rhh_back #(
  parameter int CAPACITY    = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  output logic                        ready_o,
  input  logic                        q_valid_i,
  input  rhh_pkg::req_t               q_req_i,
  input  logic [$clog2(CAPACITY)-1:0] q_home_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output rhh_pkg::rsp_t               out_data_o
);
  import rhh_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int DW = IW;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = KEY_WIDTH;
  localparam int VW = VALUE_WIDTH;
  localparam int WW = 1 + DW + KW + VW;

  back_state_e     state_q, state_d;
  logic [1:0]      act_q;
  logic [KW-1:0]   key_q, ck_q;
  logic [VW-1:0]   val_q, cv_q;
  logic [IW-1:0]   home_q, p_q, clr_q, p_nxt;
  logic [DW-1:0]   cd_q;
  logic [CW-1:0]   n_q, count_q;
  logic            hit_q, out_valid_q;
  logic [31:0]     rv_q;
  logic [1:0]      st_q;
  rsp_t            out_q;

  logic            we;
  logic [IW-1:0]   waddr, raddr;
  logic [WW-1:0]   wdata, rdata;
  logic            rvld;
  logic [DW-1:0]   rdist;
  logic [KW-1:0]   rkey;
  logic [VW-1:0]   rval;
  logic            match, last, free, swap, shift_stop, out_free;

  rhh_ram #(.WIDTH(WW), .DEPTH(CAPACITY)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Slot word fields.
  assign rvld  = rdata[WW-1];
  assign rdist = rdata[KW+VW +: DW];
  assign rkey  = rdata[VW +: KW];
  assign rval  = rdata[VW-1:0];

  assign p_nxt      = (p_q == IW'(CAPACITY - 1)) ? '0 : p_q + IW'(1);
  assign match      = rvld && (rkey == key_q);
  assign last       = (n_q == CW'(CAPACITY - 1));
  assign free       = !rvld;
  assign swap       = rvld && (rdist < cd_q);
  assign shift_stop = !rvld || (rdist == '0) || last;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign ready_o     = (state_q != BK_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_CLEAR: if (clr_q == IW'(CAPACITY - 1)) state_d = BK_IDLE;
      BK_IDLE:  if (q_valid_i) state_d = BK_START;
      BK_START: state_d = (act_q == ACT_UNUSED) ? BK_DONE : BK_FIND;
      BK_FIND: begin
        if (match) begin
          state_d = (act_q == ACT_REMOVE) ? BK_SHIFT : BK_DONE;
        end else if (free || last) begin
          if (act_q == ACT_INSERT && count_q != CW'(CAPACITY)) state_d = BK_PSTART;
          else state_d = BK_DONE;
        end
      end
      BK_PSTART: state_d = BK_PLACE;
      BK_PLACE:  if (free) state_d = BK_DONE;
      BK_SHIFT:  if (shift_stop) state_d = BK_DONE;
      BK_DONE:   if (out_free) state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  // Memory controls and queue pop.
  always_comb begin
    we      = 1'b0;
    waddr   = p_q;
    wdata   = '0;
    raddr   = p_nxt;
    q_pop_o = 1'b0;
    case (state_q)
      BK_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
      end
      BK_IDLE:   q_pop_o = q_valid_i;
      BK_START:  raddr = home_q;
      BK_PSTART: raddr = home_q;
      BK_FIND: begin
        if (match && act_q == ACT_INSERT) begin
          we    = 1'b1;
          wdata = {1'b1, rdist, rkey, val_q};
        end
      end
      BK_PLACE: begin
        if (free || swap) begin
          we    = 1'b1;
          wdata = {1'b1, cd_q, ck_q, cv_q};
        end
      end
      BK_SHIFT: begin
        we = 1'b1;
        if (shift_stop) wdata = '0;
        else wdata = {1'b1, rdist - DW'(1), rkey, rval};
        // Read ahead one past the slot being moved back.
        raddr = (p_nxt == IW'(CAPACITY - 1)) ? '0 : p_nxt + IW'(1);
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_CLEAR) clr_q <= clr_q + IW'(1);
      if (state_q == BK_PLACE && free) count_q <= count_q + CW'(1);
      if (state_q == BK_SHIFT && shift_stop) count_q <= count_q - CW'(1);
      if (state_q == BK_DONE && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        act_q  <= q_req_i.action;
        key_q  <= KW'(q_req_i.lookup_key);
        val_q  <= VW'(q_req_i.entry_value);
        home_q <= q_home_i;
      end
      BK_START: begin
        p_q   <= home_q;
        n_q   <= '0;
        hit_q <= 1'b0;
        rv_q  <= '0;
        st_q  <= ST_OK;
      end
      BK_FIND: begin
        if (match) begin
          hit_q <= 1'b1;
          n_q   <= '0;
          if (act_q == ACT_LOOKUP) rv_q <= 32'(rval);
        end else if (free || last) begin
          if (act_q != ACT_INSERT) st_q <= ST_NOT_FOUND;
          else if (count_q == CW'(CAPACITY)) st_q <= ST_FULL;
        end else begin
          p_q <= p_nxt;
          n_q <= n_q + CW'(1);
        end
      end
      BK_PSTART: begin
        p_q  <= home_q;
        ck_q <= key_q;
        cv_q <= val_q;
        cd_q <= '0;
      end
      BK_PLACE: begin
        p_q <= p_nxt;
        if (swap) begin
          ck_q <= rkey;
          cv_q <= rval;
          cd_q <= rdist + DW'(1);
        end else begin
          cd_q <= cd_q + DW'(1);
        end
      end
      BK_SHIFT: begin
        if (!shift_stop) begin
          p_q <= p_nxt;
          n_q <= n_q + CW'(1);
        end
      end
      BK_DONE: begin
        if (out_free) begin
          out_q.hit          <= hit_q;
          out_q.read_value   <= rv_q;
          out_q.status       <= st_q;
          out_q.stored_count <= 5'(count_q);
        end
      end
      default: ;
    endcase
  end

endmodule

// File: sv/robin_hood_hash_table.sv
// ----------------------------------------------------------------------------
// robin_hood_hash_table
// Fixed-capacity key/value map with Robin Hood probing and shift-back delete.
// ----------------------------------------------------------------------------
// Requests enter on the in channel (in_valid_i, in_stall_o, in_data_i) as
// one beat: action, key, precomputed hash and value. Each request returns
// exactly one response beat on the out channel (out_valid_o, out_stall_i,
// out_data_o) with hit flag, read value, status and occupancy.
// The front cannot take a new beat until it has pushed the last one: it forms
// the home slot by a reciprocal multiply and hands the request to the back
// through a two-entry queue, so the next request is prepared while the back
// works. The back walks the probe chain in the slot memory one slot per
// cycle: a lookup responds when its probe chain ends, an insert of a new key
// adds a second walk to the first free slot, a remove adds the backward shift.
// After reset the back sweeps the slot memory clear and no request is taken
// until then. A stalled response holds in the output register; the back then
// waits, and the queue and front fill before the in channel stalls for good.
// ----------------------------------------------------------------------------
module robin_hood_hash_table #(
  parameter int CAPACITY    = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rhh_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rhh_pkg::rsp_t out_data_o
);
  import rhh_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int QW = $bits(req_t) + IW;

  logic          ready, push, full, pop, q_valid;
  req_t          push_req;
  logic [IW-1:0] push_home;
  logic [QW-1:0] q_data;

  // Front: accept and compute home slot.
  rhh_front #(.CAPACITY(CAPACITY)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (ready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .push_req_o (push_req),
    .push_home_o(push_home),
    .full_i     (full)
  );

  // Queue between front and back.
  rhh_fifo #(.WIDTH(QW)) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i({push_req, push_home}),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .rdata_o(q_data)
  );

  // Back: probe sequencer over the slot memory.
  rhh_back #(
    .CAPACITY   (CAPACITY),
    .KEY_WIDTH  (KEY_WIDTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ready_o    (ready),
    .q_valid_i  (q_valid),
    .q_req_i    (q_data[QW-1:IW]),
    .q_home_i   (q_data[IW-1:0]),
    .q_pop_o    (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
